/* hw/rtl/rmq_pkg.sv */
// rmq_pkg: request types, sideband structs and fixed widths for the
// rotation matrix to quaternion pipeline; depends on nothing
`default_nettype none

package rmq_pkg;

    localparam int ONE_Q14    = 16384;
    localparam int SQRT_STEPS = 16;
    localparam int DIV_STEPS  = 16;
    localparam int RAD_W      = 31;
    localparam int ROOT_W     = 16;
    localparam int DEN_W      = 17;
    localparam int NUM_W      = 31;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic               bad_input;
    } quat_t;

    // travels beside the root pipeline
    typedef struct packed {
        logic               diag;
        axis_t              axis;
        logic               bad;
        logic signed [17:0] d0;
        logic signed [17:0] d1;
        logic signed [17:0] d2;
    } side_t;

    // travels beside the divider pipeline
    typedef struct packed {
        logic              diag;
        axis_t             axis;
        logic              bad;
        logic [2:0]        neg;
        logic [2:0]        ovf;
        logic [ROOT_W-1:0] half;
    } dside_t;

endpackage

`default_nettype wire

/* hw/rtl/rmq_isqrt.sv */
// rmq_isqrt: pipelined integer square root, one result bit per stage
// depends on rmq_pkg
`default_nettype none

module rmq_isqrt (
    input  wire                              clk,
    input  wire [rmq_pkg::SQRT_STEPS-1:0]    en,
    input  wire [rmq_pkg::RAD_W-1:0]         rad,
    output logic [rmq_pkg::ROOT_W-1:0]       root
);
    import rmq_pkg::*;

    logic [RAD_W-1:0]  rem_reg  [SQRT_STEPS];
    logic [ROOT_W-1:0] res_reg  [SQRT_STEPS];
    logic [RAD_W-1:0]  rem_next [SQRT_STEPS];
    logic [ROOT_W-1:0] res_next [SQRT_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_step
            localparam int I = SQRT_STEPS - 1 - k;
            logic [RAD_W-1:0]  rem_in;
            logic [ROOT_W-1:0] res_in;
            logic [RAD_W+1:0]  trial;
            logic              fits;

            if (k == 0)
            begin : g_first
                assign rem_in = rad;
                assign res_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign res_in = res_reg[k-1];
            end

            // (res + 2^i)^2 - res^2
            always_comb
            begin
                trial = ({{(RAD_W+2-ROOT_W){1'b0}}, res_in} << (I + 1))
                      + ((RAD_W+2)'(1) << (2 * I));
                fits  = {2'b00, rem_in} >= trial;
                rem_next[k] = fits ? RAD_W'({2'b00, rem_in} - trial) : rem_in;
                res_next[k] = fits ? (res_in | (ROOT_W'(1) << I)) : res_in;
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k] <= rem_next[k];
                    res_reg[k] <= res_next[k];
                end
            end
        end
    endgenerate

    assign root = res_reg[SQRT_STEPS-1];

endmodule

`default_nettype wire

/* hw/rtl/rmq_div.sv */
// rmq_div: pipelined restoring divider, one quotient bit per stage
// depends on rmq_pkg
`default_nettype none

module rmq_div (
    input  wire                              clk,
    input  wire [rmq_pkg::DIV_STEPS-1:0]     en,
    input  wire [rmq_pkg::NUM_W-1:0]         num,
    input  wire [rmq_pkg::DEN_W-1:0]         den,
    output logic [rmq_pkg::DIV_STEPS-1:0]    quo
);
    import rmq_pkg::*;

    logic [NUM_W-1:0]     rem_reg  [DIV_STEPS];
    logic [DEN_W-1:0]     den_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_reg  [DIV_STEPS];
    logic [NUM_W-1:0]     rem_next [DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_next [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            localparam int I = DIV_STEPS - 1 - k;
            logic [NUM_W-1:0]     rem_in;
            logic [DEN_W-1:0]     den_in;
            logic [DIV_STEPS-1:0] quo_in;
            logic [NUM_W+1:0]     trial;
            logic                 fits;

            if (k == 0)
            begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            always_comb
            begin
                trial = {{(NUM_W+2-DEN_W){1'b0}}, den_in} << I;
                fits  = {2'b00, rem_in} >= trial;
                rem_next[k] = fits ? NUM_W'({2'b00, rem_in} - trial) : rem_in;
                quo_next[k] = fits ? (quo_in | (DIV_STEPS'(1) << I)) : quo_in;
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k] <= rem_next[k];
                    den_reg[k] <= den_in;
                    quo_reg[k] <= quo_next[k];
                end
            end
        end
    endgenerate

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

/* hw/rtl/rotation_matrix_to_quaternion_top.sv */
// rotation_matrix_to_quaternion_top: shepperd matrix to quaternion pipeline
// depends on rmq_pkg, rmq_isqrt, rmq_div
//
//  channel | payload | handshake            | role
//  --------+---------+----------------------+-----------------------
//  matrix  | mat     | mat_valid/mat_stall  | request in, one matrix
//  quat    | quat    | quat_valid/quat_stall| request out, one quat
//
// one request enters per cycle unless every stage is full and the output stalls;
// a request passes select, prepare, 16 root stages, divide setup, 16 quotient stages,
// and the output register. the bit-per-stage root and dividers set the depth
// each stage holds its request until the next one frees, so a stall on the
// output only stops the input once every stage is full; empty stages close up
// reset clears the stage valid bits only
`default_nettype none

module rotation_matrix_to_quaternion_top (
    input  wire            clk,
    input  wire            rst_n,
    input  rmq_pkg::mat_t  mat,
    input  wire            mat_valid,
    output logic           mat_stall,
    output rmq_pkg::quat_t quat,
    output logic           quat_valid,
    input  wire            quat_stall
);
    import rmq_pkg::*;

    // stage map
    localparam int S_SEL  = 0;
    localparam int S_PREP = 1;
    localparam int S_SQ0  = 2;
    localparam int S_DIVP = S_SQ0 + SQRT_STEPS;
    localparam int S_DV0  = S_DIVP + 1;
    localparam int S_OUT  = S_DV0 + DIV_STEPS;
    localparam int N_ST   = S_OUT + 1;

    logic [N_ST-1:0] v_reg;
    logic [N_ST-1:0] v_next;
    logic [N_ST-1:0] ready;

    // stage valid bits and the ready ripple
    genvar s;
    generate
        for (s = 0; s < N_ST; s++)
        begin : g_ctl
            logic up_valid;
            if (s == 0)
            begin : g_in
                assign up_valid = mat_valid;
            end
            else
            begin : g_mid
                assign up_valid = v_reg[s-1];
            end
            if (s == N_ST - 1)
            begin : g_last
                assign ready[s] = !v_reg[s] || !quat_stall;
            end
            else
            begin : g_chain
                assign ready[s] = !v_reg[s] || ready[s+1];
            end
            assign v_next[s] = ready[s] ? up_valid : v_reg[s];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign mat_stall  = !ready[0];
    assign quat_valid = v_reg[S_OUT];

    // stage 0: trace sign and largest diagonal
    mat_t               mat_reg;
    logic signed [17:0] tr_reg;
    logic               diag_reg;
    axis_t              axis_reg;
    logic signed [17:0] tr_next;
    axis_t              axis_next;

    always_comb
    begin
        tr_next   = 18'(mat.m00) + 18'(mat.m11) + 18'(mat.m22);
        axis_next = AXIS_X;
        if (mat.m11 > mat.m00)
            axis_next = AXIS_Y;
        if (mat.m22 > ((axis_next == AXIS_Y) ? mat.m11 : mat.m00))
            axis_next = AXIS_Z;
    end

    always_ff @(posedge clk)
    begin
        if (ready[S_SEL])
        begin
            mat_reg  <= mat;
            tr_reg   <= tr_next;
            diag_reg <= !(tr_next > 18'sd0);
            axis_reg <= axis_next;
        end
    end

    // stage 1: radicand and the three numerators
    side_t              prep_next;
    side_t              prep_reg;
    logic signed [18:0] rad_s;
    logic [16:0]        rad_reg;
    logic [16:0]        rad_next;
    logic signed [15:0] maa, mbb, mcc;

    always_comb
    begin
        prep_next      = '0;
        prep_next.diag = diag_reg;
        prep_next.axis = axis_reg;
        maa = mat_reg.m00;
        mbb = mat_reg.m11;
        mcc = mat_reg.m22;
        if (!diag_reg)
        begin
            prep_next.d0 = 18'(mat_reg.m12) - 18'(mat_reg.m21);
            prep_next.d1 = 18'(mat_reg.m20) - 18'(mat_reg.m02);
            prep_next.d2 = 18'(mat_reg.m01) - 18'(mat_reg.m10);
        end
        else
        begin
            unique case (axis_reg)
                AXIS_Y:
                begin
                    maa = mat_reg.m11; mbb = mat_reg.m22; mcc = mat_reg.m00;
                    prep_next.d0 = 18'(mat_reg.m20) - 18'(mat_reg.m02);
                    prep_next.d1 = 18'(mat_reg.m12) + 18'(mat_reg.m21);
                    prep_next.d2 = 18'(mat_reg.m10) + 18'(mat_reg.m01);
                end
                AXIS_Z:
                begin
                    maa = mat_reg.m22; mbb = mat_reg.m00; mcc = mat_reg.m11;
                    prep_next.d0 = 18'(mat_reg.m01) - 18'(mat_reg.m10);
                    prep_next.d1 = 18'(mat_reg.m20) + 18'(mat_reg.m02);
                    prep_next.d2 = 18'(mat_reg.m21) + 18'(mat_reg.m12);
                end
                default:
                begin
                    prep_next.d0 = 18'(mat_reg.m12) - 18'(mat_reg.m21);
                    prep_next.d1 = 18'(mat_reg.m01) + 18'(mat_reg.m10);
                    prep_next.d2 = 18'(mat_reg.m02) + 18'(mat_reg.m20);
                end
            endcase
        end
        if (!diag_reg)
            rad_s = 19'(tr_reg) + 19'(ONE_Q14);
        else
            rad_s = 19'(maa) - 19'(mbb) - 19'(mcc) + 19'(ONE_Q14);
        // not a rotation: keep the root path sane, result gets masked
        prep_next.bad = diag_reg && !(rad_s > 19'sd0);
        rad_next      = prep_next.bad ? 17'd1 : rad_s[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (ready[S_PREP])
        begin
            prep_reg <= prep_next;
            rad_reg  <= rad_next;
        end
    end

    // root stages, sideband travels alongside
    logic [ROOT_W-1:0] root;
    side_t             sq_side_reg [SQRT_STEPS];

    rmq_isqrt u_isqrt (
        .clk  (clk),
        .en   (ready[S_DIVP-1:S_SQ0]),
        .rad  ({rad_reg, 14'd0}),
        .root (root)
    );

    generate
        for (s = 0; s < SQRT_STEPS; s++)
        begin : g_sq_side
            always_ff @(posedge clk)
            begin
                if (ready[S_SQ0 + s])
                    sq_side_reg[s] <= (s == 0) ? prep_reg : sq_side_reg[(s == 0) ? 0 : s-1];
            end
        end
    endgenerate

    // divide setup: magnitude, rounding bias, overflow past 16 quotient bits
    side_t             sq_last;
    dside_t            dvp_next;
    dside_t            dvp_reg;
    logic [NUM_W-1:0]  num_next [3];
    logic [NUM_W-1:0]  num_reg  [3];
    logic [DEN_W-1:0]  den_reg;
    logic signed [17:0] dsel [3];
    logic [16:0]       mag  [3];

    assign sq_last = sq_side_reg[SQRT_STEPS-1];

    always_comb
    begin
        dsel[0] = sq_last.d0;
        dsel[1] = sq_last.d1;
        dsel[2] = sq_last.d2;
        dvp_next      = '0;
        dvp_next.diag = sq_last.diag;
        dvp_next.axis = sq_last.axis;
        dvp_next.bad  = sq_last.bad;
        dvp_next.half = ROOT_W'(({1'b0, root} + 17'd1) >> 1);
        for (int n = 0; n < 3; n++)
        begin
            dvp_next.neg[n] = dsel[n][17];
            mag[n]          = dsel[n][17] ? 17'(-dsel[n]) : dsel[n][16:0];
            num_next[n]     = {mag[n], 14'd0} + NUM_W'(root);
            dvp_next.ovf[n] = {2'b00, num_next[n]}
                              >= {root, 1'b0, 16'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[S_DIVP])
        begin
            dvp_reg <= dvp_next;
            den_reg <= {root, 1'b0};
            for (int n = 0; n < 3; n++)
                num_reg[n] <= num_next[n];
        end
    end

    // quotient stages
    logic [DIV_STEPS-1:0] quo [3];
    dside_t               dv_side_reg [DIV_STEPS];

    generate
        for (s = 0; s < 3; s++)
        begin : g_div
            rmq_div u_div (
                .clk (clk),
                .en  (ready[S_OUT-1:S_DV0]),
                .num (num_reg[s]),
                .den (den_reg),
                .quo (quo[s])
            );
        end
        for (s = 0; s < DIV_STEPS; s++)
        begin : g_dv_side
            always_ff @(posedge clk)
            begin
                if (ready[S_DV0 + s])
                    dv_side_reg[s] <= (s == 0) ? dvp_reg : dv_side_reg[(s == 0) ? 0 : s-1];
            end
        end
    endgenerate

    // output stage: sign, saturation, placement
    function automatic logic [15:0] sat_q(input logic [15:0] q, input logic neg,
                                          input logic ovf);
        logic [15:0] r;
        if (neg)
            r = (ovf || q > 16'd32768) ? 16'h8000 : 16'(~q + 16'd1);
        else
            r = (ovf || q > 16'd32767) ? 16'h7fff : q;
        return r;
    endfunction

    dside_t      dv_last;
    logic [15:0] c0, c1, c2;
    quat_t       quat_next;
    quat_t       quat_reg;

    assign dv_last = dv_side_reg[DIV_STEPS-1];

    always_comb
    begin
        c0 = sat_q(quo[0], dv_last.neg[0], dv_last.ovf[0]);
        c1 = sat_q(quo[1], dv_last.neg[1], dv_last.ovf[1]);
        c2 = sat_q(quo[2], dv_last.neg[2], dv_last.ovf[2]);
        quat_next = '0;
        if (dv_last.bad)
            quat_next.bad_input = 1'b1;
        else if (!dv_last.diag)
        begin
            quat_next.qx = c0;
            quat_next.qy = c1;
            quat_next.qz = c2;
            quat_next.qw = dv_last.half;
        end
        else
        begin
            quat_next.qw = c0;
            unique case (dv_last.axis)
                AXIS_Y:
                begin
                    quat_next.qy = dv_last.half;
                    quat_next.qz = c1;
                    quat_next.qx = c2;
                end
                AXIS_Z:
                begin
                    quat_next.qz = dv_last.half;
                    quat_next.qx = c1;
                    quat_next.qy = c2;
                end
                default:
                begin
                    quat_next.qx = dv_last.half;
                    quat_next.qy = c1;
                    quat_next.qz = c2;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[S_OUT])
            quat_reg <= quat_next;
    end

    assign quat = quat_reg;

    // input stall only when every stage holds a request
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        mat_stall |-> (&v_reg))
        else $error("input stalled with an empty stage");

    // a taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (quat_valid && !quat_stall && !v_reg[S_OUT-1]) |=> !quat_valid)
        else $error("result repeated after delivery");

    // a result shows up only from a request that went through the divider
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(quat_valid) |-> $past(v_reg[S_OUT-1]))
        else $error("result appeared without a request behind it");

endmodule

`default_nettype wire

/* dv/tb_rotation_matrix_to_quaternion_top.sv */
// tb_rotation_matrix_to_quaternion_top: self-checking bench for the matrix to
// quaternion pipeline; directed table then random matrices, checked against
// a shepperd predictor; depends on rmq_pkg and rotation_matrix_to_quaternion_top
`default_nettype none

module tb_rotation_matrix_to_quaternion_top;
    import rmq_pkg::*;

    localparam int N_RANDOM    = 900;
    localparam int LATENCY     = 36;
    localparam int WATCHDOG    = 20000;
    localparam int N_DIRECTED  = 20;
    localparam logic signed [15:0] ONE = 16'sd16384;

    logic   clk;
    logic   rst_n;
    mat_t   mat;
    logic   mat_valid;
    logic   mat_stall;
    quat_t  quat;
    logic   quat_valid;
    logic   quat_stall;

    rotation_matrix_to_quaternion_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .mat        (mat),
        .mat_valid  (mat_valid),
        .mat_stall  (mat_stall),
        .quat       (quat),
        .quat_valid (quat_valid),
        .quat_stall (quat_stall)
    );

    // clock, period 12
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    quat_t pending_quats[$];
    int    n_errors;
    int    idle_cycles;
    bit    drain_hold;     // receiver hold-off for the pressure phase
    bit    no_idle;        // stretch with no idling on either side

    // ------------------------------------------------------------------
    // predictor: shepperd conversion in q2.14 integer arithmetic
    // ------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // d*8192/r, nearest, ties away from zero
    function automatic logic signed [15:0] half_quotient(longint d, longint unsigned r);
        longint unsigned mag;
        longint          q;
        mag = (d < 0) ? -d : d;
        q   = longint'(((mag << 14) + r) / (2 * r));
        return clamp16(d < 0 ? -q : q);
    endfunction

    function automatic quat_t matrix_to_quat(mat_t mx);
        longint          m[3][3];
        longint          tr;
        longint          rad;
        longint unsigned r;
        logic signed [15:0] q[4];
        int              a;
        int              b;
        int              c;
        quat_t           res;
        m[0][0] = mx.m00; m[0][1] = mx.m01; m[0][2] = mx.m02;
        m[1][0] = mx.m10; m[1][1] = mx.m11; m[1][2] = mx.m12;
        m[2][0] = mx.m20; m[2][1] = mx.m21; m[2][2] = mx.m22;
        res = '0;
        tr  = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0)
        begin
            rad  = tr + ONE_Q14;
            r    = int_sqrt(longint'(rad) << 14);
            q[0] = half_quotient(m[1][2] - m[2][1], r);
            q[1] = half_quotient(m[2][0] - m[0][2], r);
            q[2] = half_quotient(m[0][1] - m[1][0], r);
            q[3] = clamp16(longint'((r + 1) >> 1));
        end
        else
        begin
            // largest diagonal, lower index wins a tie
            a = AXIS_X;
            if (m[1][1] > m[0][0]) a = AXIS_Y;
            if (m[2][2] > m[a][a]) a = AXIS_Z;
            b   = (a + 1) % 3;
            c   = (b + 1) % 3;
            rad = m[a][a] - m[b][b] - m[c][c] + ONE_Q14;
            if (rad <= 0)
            begin
                res.bad_input = 1'b1;
                return res;
            end
            r    = int_sqrt(longint'(rad) << 14);
            q[a] = clamp16(longint'((r + 1) >> 1));
            q[3] = half_quotient(m[b][c] - m[c][b], r);
            q[b] = half_quotient(m[a][b] + m[b][a], r);
            q[c] = half_quotient(m[a][c] + m[c][a], r);
        end
        res.qx = q[0];
        res.qy = q[1];
        res.qz = q[2];
        res.qw = q[3];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // directed table; known rows carry a typed-in quaternion
    // ------------------------------------------------------------------
    typedef struct {
        mat_t  m;
        bit    known;
        quat_t q;
    } dir_row_t;

    dir_row_t dir_rows[N_DIRECTED];

    function automatic mat_t diag_mat(logic signed [15:0] a, logic signed [15:0] b,
                                      logic signed [15:0] c);
        mat_t x;
        x     = '0;
        x.m00 = a;
        x.m11 = b;
        x.m22 = c;
        return x;
    endfunction

    initial
    begin
        // identity: trace branch, w = 1
        dir_rows[0]  = '{diag_mat(ONE, ONE, ONE), 1, '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0}};
        // 180 degrees about x, y, z: diagonal branch, one axis each
        dir_rows[1]  = '{diag_mat(ONE, -ONE, -ONE), 1,
                         '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0}};
        dir_rows[2]  = '{diag_mat(-ONE, ONE, -ONE), 1,
                         '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0}};
        dir_rows[3]  = '{diag_mat(-ONE, -ONE, ONE), 1,
                         '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0}};
        // all zeros: zero trace, radicand one
        dir_rows[4]  = '{diag_mat(0, 0, 0), 1, '{16'sd8192, 16'sd0, 16'sd0, 16'sd0, 1'b0}};
        // equal negative diagonals: x keeps the tie, root of two and of three
        dir_rows[5]  = '{diag_mat(-ONE, -ONE, -ONE), 1,
                         '{16'sd11585, 16'sd0, 16'sd0, 16'sd0, 1'b0}};
        dir_rows[6]  = '{diag_mat(16'sh8000, 16'sh8000, 16'sh8000), 1,
                         '{16'sd14189, 16'sd0, 16'sd0, 16'sd0, 1'b0}};
        // remaining rows checked by the predictor
        dir_rows[7]  = '{diag_mat(16'sh7fff, 16'sh7fff, 16'sh7fff), 0, '0};
        dir_rows[8]  = '{diag_mat(16'sh7fff, 16'sh8000, 16'sh8000), 0, '0};
        dir_rows[9]  = '{diag_mat(100, 100, -200), 0, '0};        // zero trace, tie
        dir_rows[10] = '{diag_mat(-5, -5, -5), 0, '0};            // three-way tie
        dir_rows[11] = '{{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
                          16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff}, 0, '0};
        dir_rows[12] = '{{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                          16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 0, '0};
        dir_rows[13] = '{{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
                          16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 0, '0};
        dir_rows[14] = '{{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
                          16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000}, 0, '0};
        dir_rows[15] = '{{-16'sd20000, 16'sh7fff, 16'sh8000, 16'sh8000, -16'sd20000,
                          16'sh7fff, 16'sh7fff, 16'sh8000, 16'sd8000}, 0, '0};
        // 90 degrees about z
        dir_rows[16] = '{{16'sd0, -ONE, 16'sd0, ONE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ONE},
                         0, '0};
        dir_rows[17] = '{diag_mat(1, 0, 0), 0, '0};               // smallest positive trace
        dir_rows[18] = '{diag_mat(-ONE, ONE, ONE), 0, '0};
        dir_rows[19] = '{diag_mat(-16383, -16383, ONE), 0, '0};
    end

    // random test matrix: bounded entries, one dominant diagonal, or raw random bits
    function automatic mat_t random_matrix();
        mat_t x;
        int   kind;
        x    = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            // bounded entries, each drawn within the -1..1 range of a true rotation
            x.m00 = 16'($signed($urandom_range(0, 32768)) - 16384);
            x.m01 = 16'($signed($urandom_range(0, 32768)) - 16384);
            x.m02 = 16'($signed($urandom_range(0, 32768)) - 16384);
            x.m10 = 16'($signed($urandom_range(0, 32768)) - 16384);
            x.m11 = 16'($signed($urandom_range(0, 32768)) - 16384);
            x.m12 = 16'($signed($urandom_range(0, 32768)) - 16384);
            x.m20 = 16'($signed($urandom_range(0, 32768)) - 16384);
            x.m21 = 16'($signed($urandom_range(0, 32768)) - 16384);
            x.m22 = 16'($signed($urandom_range(0, 32768)) - 16384);
        end
        else if (kind < 8)
        begin
            // pick one dominant diagonal so the diagonal branch is exercised
            x.m00 = 16'($signed($urandom_range(0, 2000)) - 16384);
            x.m11 = 16'($signed($urandom_range(0, 2000)) - 16384);
            x.m22 = 16'($signed($urandom_range(0, 2000)) - 16384);
            case ($urandom_range(0, 2))
                0: x.m00 = 16'($urandom_range(0, 16384));
                1: x.m11 = 16'($urandom_range(0, 16384));
                default: x.m22 = 16'($urandom_range(0, 16384));
            endcase
        end
        return x;
    endfunction

    // ------------------------------------------------------------------
    // reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // sender: one request per call, holds until accepted
    // valid stays up after acceptance; the caller drops it when done
    // ------------------------------------------------------------------
    task automatic send_matrix(mat_t mx, bit idle_ok);
        while (idle_ok && !no_idle && $urandom_range(0, 99) < 30)
        begin
            mat_valid <= 1'b0;
            @(posedge clk);
        end
        mat       <= mx;
        mat_valid <= 1'b1;
        @(posedge clk);
        while (mat_stall) @(posedge clk);
    endtask

    // expectation is queued by the monitor on acceptance, not here
    always @(posedge clk)
    begin
        if (rst_n && mat_valid && !mat_stall)
            pending_quats.push_back(matrix_to_quat(mat));
    end

    // the known rows check the predictor itself against the typed-in value
    task automatic check_table_row(int i);
        quat_t p;
        quat_t t;
        p = matrix_to_quat(dir_rows[i].m);
        t = dir_rows[i].q;
        if (dir_rows[i].known)
        begin
            if (p.qx !== t.qx) report_mismatch($sformatf("table row %0d qx", i), p.qx, t.qx);
            if (p.qy !== t.qy) report_mismatch($sformatf("table row %0d qy", i), p.qy, t.qy);
            if (p.qz !== t.qz) report_mismatch($sformatf("table row %0d qz", i), p.qz, t.qz);
            if (p.qw !== t.qw) report_mismatch($sformatf("table row %0d qw", i), p.qw, t.qw);
            if (p.bad_input !== t.bad_input)
                report_mismatch($sformatf("table row %0d bad_input", i),
                                p.bad_input, t.bad_input);
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: random stall, no stall in the no-idle stretch, hold-off during the pressure phase
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quat_stall <= 1'b1;
        else if (drain_hold)
            quat_stall <= 1'b1;
        else if (no_idle)
            quat_stall <= 1'b0;
        else
            quat_stall <= ($urandom_range(0, 99) < 30);
    end

    // result checker
    always @(posedge clk)
    begin
        quat_t want;
        if (rst_n && quat_valid && !quat_stall)
        begin
            if (pending_quats.size() == 0)
            begin
                report_mismatch("unexpected result", quat.qw, 0);
            end
            else
            begin
                want = pending_quats.pop_front();
                if (quat.qx !== want.qx) report_mismatch("qx", quat.qx, want.qx);
                if (quat.qy !== want.qy) report_mismatch("qy", quat.qy, want.qy);
                if (quat.qz !== want.qz) report_mismatch("qz", quat.qz, want.qz);
                if (quat.qw !== want.qw) report_mismatch("qw", quat.qw, want.qw);
                if (quat.bad_input !== want.bad_input)
                    report_mismatch("bad_input", quat.bad_input, want.bad_input);
            end
        end
    end

    // watchdog: cycles with no request moving on either side
    always @(posedge clk)
    begin
        if ((mat_valid && !mat_stall) || (quat_valid && !quat_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int hold_count;
        rst_n       = 1'b0;
        mat         = '0;
        mat_valid   = 1'b0;
        n_errors    = 0;
        idle_cycles = 0;
        drain_hold  = 1'b0;
        no_idle     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            check_table_row(i);
            send_matrix(dir_rows[i].m, 1);
        end
        mat_valid <= 1'b0;

        // sender pause until everything has drained
        while (pending_quats.size() != 0) @(posedge clk);

        // pressure: receiver holds off while sender keeps offering
        drain_hold <= 1'b1;
        fork
            begin
                hold_count = 0;
                while (hold_count < 3 * LATENCY)
                begin
                    @(posedge clk);
                    hold_count++;
                end
                drain_hold <= 1'b0;
            end
            begin
                for (int i = 0; i < 80; i++) send_matrix(random_matrix(), 0);
                mat_valid <= 1'b0;
            end
        join
        @(posedge clk);

        // random traffic; a stretch in the middle runs without idling
        for (int i = 0; i < N_RANDOM - 80; i++)
        begin
            if (i == 300) no_idle <= 1'b1;
            if (i == 450) no_idle <= 1'b0;
            send_matrix(random_matrix(), 1);
        end
        mat_valid <= 1'b0;

        while (pending_quats.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
